// ----- design/rrcss_pkg.sv -----
`default_nettype none

package rrcss_pkg;

    localparam int MaxCols        = 4096;
    localparam int MaxRows        = 4096;
    localparam int MaxCellsPerCol = 16;
    localparam int RowSat         = 4095 + MaxRows;

    localparam int ColW  = $clog2(MaxCols);
    localparam int CellW = $clog2(MaxCellsPerCol);
    localparam int RowW  = $clog2(RowSat + 1);

    localparam int CfgIndexW = 4;
    localparam int CfgDataW  = 32;

    typedef enum logic [CfgIndexW-1:0] {
        CfgGridCols       = 4'd0,
        CfgRegionColStart = 4'd1,
        CfgRegionCols     = 4'd2,
        CfgRegionRowStart = 4'd3,
        CfgRegionRows     = 4'd4,
        CfgCellsPerColumn = 4'd5,
        CfgCellFormat     = 4'd6,
        CfgScaleFactor    = 4'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        Width1B = 2'd0,
        Width2B = 2'd1,
        Width4B = 2'd2,
        Width8B = 2'd3
    } width_t;

    typedef struct packed {
        logic [63:0] cell_value;
        logic        first_cell;
    } cell_in_t;

    typedef struct packed {
        logic [63:0] region_value;
        logic        last_in_row;
        logic        last_in_region;
    } cell_out_t;

    typedef struct packed {
        logic keep;
        logic last_in_row;
        logic last_in_region;
    } win_t;

    typedef struct packed {
        logic [2:0]  cell_format;
        logic [31:0] scale_factor;
    } fmt_t;

endpackage

`default_nettype wire

// ----- design/rrcss_window.sv -----
`default_nettype none

module rrcss_window (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rrcss_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [rrcss_pkg::CfgDataW-1:0]  cfg_data,
    input  wire logic                           step,
    input  wire logic                           first_cell,
    output rrcss_pkg::win_t                     win,
    output rrcss_pkg::fmt_t                     fmt
);
    import rrcss_pkg::*;

    logic [12:0] grid_cols_reg;
    logic [11:0] region_col_start_reg;
    logic [12:0] region_cols_reg;
    logic [11:0] region_row_start_reg;
    logic [12:0] region_rows_reg;
    logic [4:0]  cells_per_column_reg;
    logic [2:0]  cell_format_reg;
    logic [31:0] scale_factor_reg;

    logic [ColW-1:0]  col_reg, col_next, col_cur;
    logic [CellW-1:0] cell_reg, cell_next, cell_cur;
    logic [RowW-1:0]  row_reg, row_next, row_cur;

    logic [12:0] gcols;
    logic [4:0]  cpc;
    logic [12:0] rrows;
    logic [13:0] col_end;
    logic [13:0] row_end;
    logic        fits;
    logic        end_row;
    logic [CellW:0] cell_inc;
    logic [ColW:0]  col_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg        <= 13'd1;
            region_col_start_reg <= 12'd0;
            region_cols_reg      <= 13'd1;
            region_row_start_reg <= 12'd0;
            region_rows_reg      <= 13'd1;
            cells_per_column_reg <= 5'd1;
            cell_format_reg      <= 3'd0;
            scale_factor_reg     <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CfgGridCols:       grid_cols_reg        <= cfg_data[12:0];
                CfgRegionColStart: region_col_start_reg <= cfg_data[11:0];
                CfgRegionCols:     region_cols_reg      <= cfg_data[12:0];
                CfgRegionRowStart: region_row_start_reg <= cfg_data[11:0];
                CfgRegionRows:     region_rows_reg      <= cfg_data[12:0];
                CfgCellsPerColumn: cells_per_column_reg <= cfg_data[4:0];
                CfgCellFormat:     cell_format_reg      <= cfg_data[2:0];
                CfgScaleFactor:    scale_factor_reg     <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_cols_reg == 13'd0)
            gcols = 13'd1;
        else if (grid_cols_reg > 13'(MaxCols))
            gcols = 13'(MaxCols);
        else
            gcols = grid_cols_reg;

        if (cells_per_column_reg == 5'd0)
            cpc = 5'd1;
        else if (cells_per_column_reg > 5'(MaxCellsPerCol))
            cpc = 5'(MaxCellsPerCol);
        else
            cpc = cells_per_column_reg;

        rrows = (region_rows_reg > 13'(MaxRows)) ? 13'(MaxRows) : region_rows_reg;

        col_end = {2'b00, region_col_start_reg} + {1'b0, region_cols_reg};
        row_end = {2'b00, region_row_start_reg} + {1'b0, rrows};
        fits    = (col_end <= {1'b0, gcols}) && (region_cols_reg != 13'd0)
                  && (rrows != 13'd0);
    end

    // A first cell restarts the raster at row 0, column 0, cell 0.
    always_comb
    begin
        col_cur  = first_cell ? '0 : col_reg;
        cell_cur = first_cell ? '0 : cell_reg;
        row_cur  = first_cell ? '0 : row_reg;

        end_row = (14'(col_cur) == col_end - 14'd1) && (5'(cell_cur) == cpc - 5'd1);

        win.keep = fits
                   && (14'(col_cur) >= 14'(region_col_start_reg))
                   && (14'(col_cur) < col_end)
                   && (14'(row_cur) >= 14'(region_row_start_reg))
                   && (14'(row_cur) < row_end);
        win.last_in_row    = end_row;
        win.last_in_region = end_row && (14'(row_cur) == row_end - 14'd1);

        fmt.cell_format  = cell_format_reg;
        fmt.scale_factor = scale_factor_reg;
    end

    always_comb
    begin
        cell_inc  = {1'b0, cell_cur} + 1'b1;
        col_inc   = {1'b0, col_cur} + 1'b1;
        cell_next = cell_cur;
        col_next  = col_cur;
        row_next  = row_cur;
        if (5'(cell_inc) >= cpc)
        begin
            cell_next = '0;
            if (13'(col_inc) >= gcols)
            begin
                col_next = '0;
                if (row_cur < RowW'(RowSat))
                    row_next = row_cur + 1'b1;
            end
            else
            begin
                col_next = col_inc[ColW-1:0];
            end
        end
        else
        begin
            cell_next = cell_inc[CellW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            cell_reg <= '0;
            row_reg  <= '0;
        end
        else if (step)
        begin
            col_reg  <= col_next;
            cell_reg <= cell_next;
            row_reg  <= row_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/raster_region_crop_swap_scale_top.sv -----
`default_nettype none

// Channel   Direction  Handshake                    Payload
// cell      in         cell_valid / cell_ready      cell_item (cell_in_t)
// result    out        result_valid / result_ready  result (cell_out_t)
// cfg       in         cfg_we                       cfg_index, cfg_data
//
// One item is accepted every cycle while cell_ready is high; a kept item is registered before it is offered.
// It passes the input register and then the result register, with the scale between.
// Reset returns the configuration registers to their defaults and the raster position to zero.
// A stalled result holds its item; one more item then waits in the input register.
// The input stalls only while both registers are full and the result is not taken.

module raster_region_crop_swap_scale_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cell_valid,
    output logic                                 cell_ready,
    input  wire rrcss_pkg::cell_in_t             cell_item,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output rrcss_pkg::cell_out_t                 result,
    input  wire logic                            cfg_we,
    input  wire logic [rrcss_pkg::CfgIndexW-1:0] cfg_index,
    input  wire logic [rrcss_pkg::CfgDataW-1:0]  cfg_data
);
    import rrcss_pkg::*;

    win_t win;
    fmt_t fmt;

    logic accept;
    logic s2_load;

    logic        s1_valid_reg, s1_valid_next;
    logic [63:0] s1_value_reg;
    logic        s1_last_row_reg;
    logic        s1_last_region_reg;
    logic [63:0] s1_value_next;

    logic        out_valid_reg, out_valid_next;
    cell_out_t   out_reg;

    width_t      wsel;
    logic [63:0] masked;
    logic [63:0] maxv;
    logic [63:0] product;
    logic [63:0] scaled;
    logic [63:0] final_value;

    function automatic logic [63:0] width_mask(width_t w);
        logic [63:0] m;
        unique case (w)
            Width1B: m = 64'h0000_0000_0000_00FF;
            Width2B: m = 64'h0000_0000_0000_FFFF;
            Width4B: m = 64'h0000_0000_FFFF_FFFF;
            Width8B: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] swap_in_width(logic [63:0] v, width_t w);
        logic [63:0] r;
        unique case (w)
            Width1B: r = v;
            Width2B: r = {48'd0, v[7:0], v[15:8]};
            Width4B: r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
            Width8B: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                          v[39:32], v[47:40], v[55:48], v[63:56]};
            default: r = v;
        endcase
        return r;
    endfunction

    rrcss_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step       (accept),
        .first_cell (cell_item.first_cell),
        .win        (win),
        .fmt        (fmt)
    );

    assign wsel       = width_t'(fmt.cell_format[1:0]);
    assign s2_load    = !out_valid_reg || result_ready;
    assign cell_ready = !s1_valid_reg || s2_load;
    assign accept     = cell_valid && cell_ready;

    always_comb
    begin
        masked        = cell_item.cell_value & width_mask(wsel);
        s1_value_next = fmt.cell_format[2] ? swap_in_width(masked, wsel) : masked;

        if (accept)
            s1_valid_next = win.keep;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;
    end

    // Eight-byte cells bypass the scale; narrower cells saturate at their maximum.
    always_comb
    begin
        maxv    = width_mask(wsel);
        product = 64'(s1_value_reg[31:0]) * 64'(fmt.scale_factor);
        scaled  = {16'd0, product[63:16]};
        if (wsel == Width8B)
            final_value = s1_value_reg;
        else if (scaled > maxv)
            final_value = maxv;
        else
            final_value = scaled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg       <= s1_value_next;
            s1_last_row_reg    <= win.last_in_row;
            s1_last_region_reg <= win.last_in_region;
        end
        if (s2_load && s1_valid_reg)
        begin
            out_reg.region_value   <= final_value;
            out_reg.last_in_row    <= s1_last_row_reg;
            out_reg.last_in_region <= s1_last_region_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- design/rrcss_checker.sv -----
`default_nettype none

module rrcss_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cell_valid,
    input  wire logic                 cell_ready,
    input  wire logic                 result_valid,
    input  wire logic                 result_ready,
    input  wire rrcss_pkg::cell_out_t result
);
    import rrcss_pkg::*;

    // A stalled result keeps its item.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The input side only stalls when the output holds an item nobody takes.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ready |-> result_valid && !result_ready)
        else $error("cell_ready low without an output stall");

    // A result appearing from empty follows an accepted item that passed the input and result registers.
    a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cell_valid && cell_ready, 2))
        else $error("result appeared without an accepted item");

    // The end of the region is always the end of a row.
    a_region_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_in_region |-> result.last_in_row)
        else $error("last_in_region without last_in_row");

endmodule

bind raster_region_crop_swap_scale_top rrcss_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
